[rtl/core/jhp_pkg.sv]
// Shared types and constants for the joint histogram probability block.
package jhp_pkg;

	// Fixed field widths of the item and result ports.
	localparam int CMD_W     = 2;
	localparam int VAL_W     = 6;
	localparam int RANGE_W   = 7;
	localparam int CNT_OUT_W = 32;
	localparam int PROB_W    = 17;
	localparam int STAT_W    = 2;

	// Fraction bits of the probability and the step counter of the divider.
	localparam int FRAC_BITS = 16;
	localparam int STEP_W    = $clog2(FRAC_BITS);

	// Depth of the queue between the front and the back.
	localparam int QDEPTH = 4;

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ACC   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

	// Status codes.
	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

	// Configuration register indexes.
	localparam logic CFG_RANGE_A = 1'b0;
	localparam logic CFG_RANGE_B = 1'b1;

	// Probability of one whole, 1.0 in Q1.16.
	localparam logic [PROB_W-1:0] PROB_ONE = 17'h10000;

	// Classification of an accepted item, as the front hands it to the back.
	typedef enum logic [2:0] {
		KIND_CLEAR,
		KIND_ACC,
		KIND_QUERY,
		KIND_RANGE,
		KIND_NOP
	} kind_t;

	localparam int KIND_W = $bits(kind_t);

	// States of the back-end sequencer.
	typedef enum logic [2:0] {
		BK_SWEEP,
		BK_IDLE,
		BK_READ,
		BK_FRAC,
		BK_DIV
	} bk_state_t;

	// One result item with its strobe.
	typedef struct packed {
		logic                 valid;
		logic [CNT_OUT_W-1:0] cell_count;
		logic [PROB_W-1:0]    probability;
		logic [STAT_W-1:0]    status;
	} result_t;

endpackage

[rtl/core/jhp_front.sv]
// Front end: range registers, range check, cell index and item classification.
module jhp_front #(
	parameter int MAX_VALUES = 64,
	localparam int IDX_W = $clog2(MAX_VALUES * MAX_VALUES),
	localparam int ENT_W = jhp_pkg::KIND_W + IDX_W
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	input  logic                        cfg_index,
	input  logic [jhp_pkg::RANGE_W-1:0] cfg_data,
	input  logic [jhp_pkg::CMD_W-1:0]   command,
	input  logic [jhp_pkg::VAL_W-1:0]   value_a,
	input  logic [jhp_pkg::VAL_W-1:0]   value_b,
	output logic [ENT_W-1:0]            entry
);

	localparam int RW     = jhp_pkg::RANGE_W;
	localparam int VW     = jhp_pkg::VAL_W;
	localparam int PROD_W = VW + RW;
	localparam logic [RW-1:0] RANGE_CAP = MAX_VALUES[RW-1:0];

	logic [RW-1:0]     range_a_q;
	logic [RW-1:0]     range_b_q;
	logic [RW-1:0]     eff_a;
	logic [RW-1:0]     eff_b;
	logic              out_of_range;
	logic [PROD_W-1:0] lin_idx;
	jhp_pkg::kind_t    kind;

	// Range registers, written through the configuration channel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_a_q <= 7'd64;
			range_b_q <= 7'd64;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				jhp_pkg::CFG_RANGE_A: range_a_q <= cfg_data;
				jhp_pkg::CFG_RANGE_B: range_b_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Ranges above the table size count as the table size.
	assign eff_a = (int'(range_a_q) > MAX_VALUES) ? RANGE_CAP : range_a_q;
	assign eff_b = (int'(range_b_q) > MAX_VALUES) ? RANGE_CAP : range_b_q;

	assign out_of_range = ({1'b0, value_a} >= eff_a) || ({1'b0, value_b} >= eff_b);

	// Row-major cell index; it stays below the table depth for pairs in range.
	assign lin_idx = PROD_W'(value_a) * PROD_W'(eff_b) + PROD_W'(value_b);

	// Sort the item into the operation the back end carries out.
	always_comb begin
		unique case (command)
			jhp_pkg::CMD_CLEAR: kind = jhp_pkg::KIND_CLEAR;
			jhp_pkg::CMD_ACC:   kind = out_of_range ? jhp_pkg::KIND_RANGE : jhp_pkg::KIND_ACC;
			jhp_pkg::CMD_QUERY: kind = out_of_range ? jhp_pkg::KIND_RANGE : jhp_pkg::KIND_QUERY;
			default:            kind = jhp_pkg::KIND_NOP;
		endcase
	end

	assign entry = {kind, IDX_W'(lin_idx)};

endmodule

[rtl/core/jhp_fifo.sv]
// Small queue of classified items between the front end and the back end.
module jhp_fifo #(
	parameter int WIDTH = 15
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             full,
	output logic             empty
);

	localparam int DEPTH = jhp_pkg::QDEPTH;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

	logic [WIDTH-1:0] slots [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_FULL);
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = slots[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Item storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			slots[wr_ptr_q] <= din;
		end
	end

endmodule

[rtl/core/jhp_div.sv]
// Radix-2 restoring divider that forms the 16 fraction bits of num/den, num below den.
module jhp_div #(
	parameter int COUNT_BITS = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [COUNT_BITS-1:0]           num,
	input  logic [COUNT_BITS-1:0]           den,
	output logic                            done,
	output logic [jhp_pkg::FRAC_BITS-1:0]   quo
);

	localparam int FB = jhp_pkg::FRAC_BITS;
	localparam int SW = jhp_pkg::STEP_W;
	localparam logic [SW-1:0] STEP_FIRST = SW'(FB - 1);

	logic                  busy_q;
	logic                  done_q;
	logic [SW-1:0]         step_q;
	logic [COUNT_BITS-1:0] rem_q;
	logic [COUNT_BITS-1:0] den_q;
	logic [FB-1:0]         quo_q;
	logic [COUNT_BITS:0]   shifted;
	logic [COUNT_BITS:0]   diff;
	logic                  ge;

	// One quotient bit per cycle: double the remainder and try the subtraction.
	assign shifted = {rem_q, 1'b0};
	assign diff    = shifted - {1'b0, den_q};
	assign ge      = (shifted >= {1'b0, den_q});

	// Control of the iteration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_FIRST;
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and quotient.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[COUNT_BITS-1:0] : shifted[COUNT_BITS-1:0];
			quo_q <= {quo_q[FB-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

[rtl/core/jhp_back.sv]
// Back end: count table, sample total, clearing sweep and result formation.
module jhp_back #(
	parameter int MAX_VALUES = 64,
	parameter int COUNT_BITS = 32,
	localparam int IDX_W = $clog2(MAX_VALUES * MAX_VALUES),
	localparam int ENT_W = jhp_pkg::KIND_W + IDX_W
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [ENT_W-1:0]        head,
	input  logic                    empty,
	output logic                    pop,
	output logic                    init_busy,
	output jhp_pkg::result_t        result
);

	localparam int DEPTH = MAX_VALUES * MAX_VALUES;
	localparam int OW    = jhp_pkg::CNT_OUT_W;
	localparam int PW    = jhp_pkg::PROB_W;
	localparam int SW    = jhp_pkg::STAT_W;
	localparam int KW    = jhp_pkg::KIND_W;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);

	logic [COUNT_BITS-1:0] count_mem [DEPTH];

	jhp_pkg::bk_state_t    state_q;
	jhp_pkg::bk_state_t    state_d;
	jhp_pkg::kind_t        head_kind;
	jhp_pkg::kind_t        op_q;
	jhp_pkg::result_t      res_q;
	logic [IDX_W-1:0]      head_idx;
	logic [IDX_W-1:0]      idx_q;
	logic [IDX_W-1:0]      sweep_q;
	logic                  init_q;
	logic                  clr_emit_q;
	logic [COUNT_BITS-1:0] rdata_q;
	logic [COUNT_BITS-1:0] cnt_q;
	logic [COUNT_BITS-1:0] total_q;
	logic [COUNT_BITS-1:0] cnt_inc;
	logic [COUNT_BITS-1:0] cnt_new;
	logic [COUNT_BITS-1:0] tot_inc;
	logic                  rd_en;
	logic                  wr_en;
	logic [IDX_W-1:0]      wr_addr;
	logic [COUNT_BITS-1:0] wr_data;
	logic                  div_start;
	logic                  div_done;
	logic [jhp_pkg::FRAC_BITS-1:0] div_quo;
	logic                  emit;
	logic [OW-1:0]         emit_cnt;
	logic [PW-1:0]         emit_prob;
	logic [SW-1:0]         emit_stat;

	assign head_kind = jhp_pkg::kind_t'(head[ENT_W-1 -: KW]);
	assign head_idx  = head[IDX_W-1:0];

	// Saturating increments of the cell and of the total.
	assign cnt_inc = (rdata_q == '1) ? rdata_q : rdata_q + 1'b1;
	assign cnt_new = (op_q == jhp_pkg::KIND_ACC) ? cnt_inc : rdata_q;
	assign tot_inc = (total_q == '1) ? total_q : total_q + 1'b1;

	jhp_div #(
		.COUNT_BITS(COUNT_BITS)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (cnt_q),
		.den   (total_q),
		.done  (div_done),
		.quo   (div_quo)
	);

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= jhp_pkg::BK_SWEEP;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, memory controls and the result to emit.
	always_comb begin
		state_d   = state_q;
		pop       = 1'b0;
		rd_en     = 1'b0;
		wr_en     = 1'b0;
		wr_addr   = sweep_q;
		wr_data   = '0;
		div_start = 1'b0;
		emit      = 1'b0;
		emit_cnt  = '0;
		emit_prob = '0;
		emit_stat = jhp_pkg::STAT_OK;
		unique case (state_q)
			jhp_pkg::BK_SWEEP: begin
				wr_en = 1'b1;
				if (sweep_q == IDX_LAST) begin
					state_d = jhp_pkg::BK_IDLE;
					emit    = clr_emit_q;
				end
			end
			jhp_pkg::BK_IDLE: begin
				if (!empty) begin
					pop = 1'b1;
					case (head_kind) inside
						jhp_pkg::KIND_CLEAR: begin
							state_d = jhp_pkg::BK_SWEEP;
						end
						jhp_pkg::KIND_ACC, jhp_pkg::KIND_QUERY: begin
							rd_en   = 1'b1;
							state_d = jhp_pkg::BK_READ;
						end
						jhp_pkg::KIND_RANGE: begin
							emit      = 1'b1;
							emit_stat = jhp_pkg::STAT_RANGE;
						end
						default: begin
							emit = 1'b1;
						end
					endcase
				end
			end
			jhp_pkg::BK_READ: begin
				wr_en   = (op_q == jhp_pkg::KIND_ACC);
				wr_addr = idx_q;
				wr_data = cnt_inc;
				state_d = jhp_pkg::BK_FRAC;
			end
			jhp_pkg::BK_FRAC: begin
				emit_cnt = OW'(cnt_q);
				if (total_q == '0) begin
					emit      = 1'b1;
					emit_stat = jhp_pkg::STAT_EMPTY;
					state_d   = jhp_pkg::BK_IDLE;
				end else if (cnt_q >= total_q) begin
					// The cell holds every sample: a probability of one.
					emit      = 1'b1;
					emit_prob = jhp_pkg::PROB_ONE;
					state_d   = jhp_pkg::BK_IDLE;
				end else begin
					div_start = 1'b1;
					state_d   = jhp_pkg::BK_DIV;
				end
			end
			jhp_pkg::BK_DIV: begin
				emit_cnt  = OW'(cnt_q);
				emit_prob = {1'b0, div_quo};
				if (div_done) begin
					emit    = 1'b1;
					state_d = jhp_pkg::BK_IDLE;
				end
			end
			default: begin
				state_d = jhp_pkg::BK_IDLE;
			end
		endcase
	end

	// Sweep address, initial clear flag, sample total and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q    <= '0;
			init_q     <= 1'b1;
			clr_emit_q <= 1'b0;
			total_q    <= '0;
			res_q      <= '0;
		end else begin
			res_q.valid <= emit;
			if (emit) begin
				res_q.cell_count  <= emit_cnt;
				res_q.probability <= emit_prob;
				res_q.status      <= emit_stat;
			end
			if (state_q == jhp_pkg::BK_SWEEP) begin
				if (sweep_q == IDX_LAST) begin
					sweep_q    <= '0;
					init_q     <= 1'b0;
					clr_emit_q <= 1'b0;
				end else begin
					sweep_q <= sweep_q + 1'b1;
				end
			end
			if (pop && head_kind == jhp_pkg::KIND_CLEAR) begin
				total_q    <= '0;
				clr_emit_q <= 1'b1;
			end
			if (state_q == jhp_pkg::BK_READ && op_q == jhp_pkg::KIND_ACC) begin
				total_q <= tot_inc;
			end
		end
	end

	// Count table with a registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q <= count_mem[head_idx];
		end
		if (wr_en) begin
			count_mem[wr_addr] <= wr_data;
		end
	end

	// Operation in flight and the count it works on.
	always_ff @(posedge clk) begin
		if (pop) begin
			op_q  <= head_kind;
			idx_q <= head_idx;
		end
		if (state_q == jhp_pkg::BK_READ) begin
			cnt_q <= cnt_new;
		end
	end

	assign init_busy = init_q;
	assign result    = res_q;

	// A cell never holds more than the total, so the fraction is at most one.
	a_cell_le_total: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == jhp_pkg::BK_FRAC |-> cnt_q <= total_q)
		else $error("cell count exceeds the sample total");

	// The divider finishes only while the sequencer waits for it.
	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == jhp_pkg::BK_DIV)
		else $error("divider finished outside the divide step");

	// The initial clear ends only at the last entry of a sweep.
	a_init_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(init_q) |-> $past(state_q) == jhp_pkg::BK_SWEEP && $past(sweep_q) == IDX_LAST)
		else $error("initial clear ended early");

	// No result leaves the block during the initial clear.
	a_init_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		init_q |-> !res_q.valid)
		else $error("result emitted during the initial clear");

endmodule

[rtl/core/joint_histogram_probability.sv]
// Top level of the two-dimensional joint histogram with probability queries.
//
// Items enter on start/command/value_a/value_b and are taken at a clock edge
// with start high and busy low. Command clear zeroes the table and the total,
// accumulate adds one to the cell of the pair and to the total, query reads the
// cell. Every item gives one result on cell_count/probability/status, shown for
// exactly one cycle with done high; the receiver cannot stall it.
// Range registers are written on cfg_valid/cfg_ready (always ready) by index.
// An accepted item sits in a four-entry queue; for an accumulate or query the back
// end then runs a table read, an update and a restoring divide, and it takes the
// next item from the queue only once it has emitted the result of the last. Without
// a divide (no samples, or the cell holds every sample) the result is emitted
// straight after the update. Out-of-range pairs and the unused command are answered
// as soon as the back end takes them from the queue, with no table access. A clear
// sweeps the table one entry per cycle, MAX_VALUES*MAX_VALUES entries (4096 by
// default), and its result is registered from the write of the last entry.
// After reset the same sweep runs with busy high; busy also rises when the
// queue is full.
module joint_histogram_probability #(
	parameter int MAX_VALUES = 64,
	parameter int COUNT_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [jhp_pkg::CMD_W-1:0]     command,
	input  logic [jhp_pkg::VAL_W-1:0]     value_a,
	input  logic [jhp_pkg::VAL_W-1:0]     value_b,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic                          cfg_index,
	input  logic [jhp_pkg::RANGE_W-1:0]   cfg_data,
	output logic                          done,
	output logic [jhp_pkg::CNT_OUT_W-1:0] cell_count,
	output logic [jhp_pkg::PROB_W-1:0]    probability,
	output logic [jhp_pkg::STAT_W-1:0]    status
);

	localparam int IDX_W = $clog2(MAX_VALUES * MAX_VALUES);
	localparam int ENT_W = jhp_pkg::KIND_W + IDX_W;

	logic [ENT_W-1:0] entry;
	logic [ENT_W-1:0] head;
	logic             q_full;
	logic             q_empty;
	logic             q_pop;
	logic             init_busy;
	logic             accept;
	jhp_pkg::result_t result;

	assign cfg_ready = 1'b1;
	assign busy      = q_full || init_busy;
	assign accept    = start && !busy;

	jhp_front #(
		.MAX_VALUES(MAX_VALUES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.command  (command),
		.value_a  (value_a),
		.value_b  (value_b),
		.entry    (entry)
	);

	jhp_fifo #(
		.WIDTH(ENT_W)
	) u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (accept),
		.din   (entry),
		.pop   (q_pop),
		.dout  (head),
		.full  (q_full),
		.empty (q_empty)
	);

	jhp_back #(
		.MAX_VALUES(MAX_VALUES),
		.COUNT_BITS(COUNT_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.empty    (q_empty),
		.pop      (q_pop),
		.init_busy(init_busy),
		.result   (result)
	);

	assign done        = result.valid;
	assign cell_count  = result.cell_count;
	assign probability = result.probability;
	assign status      = result.status;

endmodule
